FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LPE_ASSERT_IMP(label, clk_sig, rstn_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LPE_ASSERT_NXT(label, clk_sig, rstn_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/lpe_pkg.sv
package lpe_pkg;

	localparam int X_W = 32;
	localparam int VAL_W = 48;
	localparam int DEG_W = 5;
	localparam int ALPHA_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEGREE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_ALPHA = CFG_IDX_W'(1);

	// multiplier works on 16-bit chunks of the 48-bit operands
	localparam int CH_W = 16;
	localparam int NUM_CH = VAL_W / CH_W;
	localparam int MUL_PASSES = 2 * NUM_CH;
	localparam int PASS_W = $clog2(MUL_PASSES + 1);

	// divider retires four quotient bits per cycle
	localparam int DIV_BPC = 4;
	localparam int DIV_CYCLES = VAL_W / DIV_BPC;

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_ABS,
		ST_DLD,
		ST_DIV,
		ST_WB,
		ST_DONE
	} lpe_state_t;

	typedef struct packed {
		logic clear;
		logic mul_en;
		logic [PASS_W-1:0] pass;
	} lpe_mac_ctl_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} lpe_div_sts_t;

	// width of the signed step coefficient (2i-1+a)*one - x
	function automatic int s_width(input int frac);
		return ((frac + 8 > 31) ? frac + 8 : 31) + 2;
	endfunction

	function automatic int idx_width(input int max_deg);
		return $clog2(max_deg + 1);
	endfunction

endpackage

FILE: rtl/lpe_sample_if.sv
interface lpe_sample_if import lpe_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [X_W-1:0] x_value;

	modport source (output valid, output x_value, input ready);
	modport sink (input valid, input x_value, output ready);
endinterface

FILE: rtl/lpe_result_if.sv
interface lpe_result_if import lpe_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [VAL_W-1:0] poly_value;
	logic saturated;

	modport source (output valid, output poly_value, output saturated, input ready);
	modport sink (input valid, input poly_value, input saturated, output ready);
endinterface

FILE: rtl/lpe_cfg_if.sv
interface lpe_cfg_if import lpe_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/laguerre_poly_eval_unit.sv
// degree 0 or 1 goes from the sample transaction straight to the result; otherwise
//   n-1 recurrence steps run, n = min(degree, MAX_DEGREE)
// each recurrence step: products on the shared 32x16 multiplier (six chunk passes),
//   division on the four-bit-per-cycle divider, plus setup and writeback states
// samples are taken one at a time, only when idle; a finished result may wait while the next is taken
// reset: arst_n clears the sequencer, the result valid and both config registers to 0
`include "assert_macros.svh"

module laguerre_poly_eval_unit import lpe_pkg::*; #(
	parameter int MAX_DEGREE = 31,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	lpe_sample_if.sink sample,
	lpe_result_if.source result,
	lpe_cfg_if.sink cfg
);

	localparam int SW = s_width(FRAC_BITS);
	localparam int AW = SW - 1;
	localparam int NW = SW + VAL_W;
	localparam int DW = NW - FRAC_BITS;
	localparam int IW = idx_width(MAX_DEGREE);
	localparam int NCMP = (IW > DEG_W) ? IW : DEG_W;
	localparam logic signed [VAL_W-1:0] ONE_VAL = VAL_W'(1) << FRAC_BITS;

	lpe_state_t state_q, state_d;
	logic [PASS_W-1:0] pass_q;
	logic res_valid_q;
	logic [DEG_W-1:0] cfg_degree_q;
	logic [ALPHA_W-1:0] cfg_alpha_q;

	logic signed [X_W-1:0] x_q;
	logic [IW-1:0] n_q;
	logic [IW-1:0] i_q;
	logic [ALPHA_W-1:0] a_q;
	logic signed [VAL_W-1:0] l1_q;
	logic signed [VAL_W-1:0] l2_q;
	logic sat_q;
	logic [AW-1:0] s_mag_q;
	logic [AW-1:0] c2_q;
	logic [VAL_W-1:0] l1_mag_q;
	logic [VAL_W-1:0] l2_mag_q;
	logic neg1_q;
	logic neg2_q;
	logic [DW-1:0] d_q;
	logic dneg_q;
	logic signed [VAL_W-1:0] poly_q;
	logic sat_out_q;

	logic accept;
	logic res_load;
	logic div_start;
	lpe_mac_ctl_t mac_ctl;
	lpe_div_sts_t div_sts;
	logic signed [NW-1:0] acc;
	logic [VAL_W-1:0] div_q;

	logic [NCMP-1:0] deg_ext;
	logic [IW-1:0] n_in;
	logic signed [VAL_W-1:0] l1_init;
	logic [SW-1:0] coef;
	logic signed [SW-1:0] s_val;
	logic [AW-1:0] s_mag;
	logic [AW-1:0] c2;
	logic [VAL_W-1:0] l1_mag;
	logic [VAL_W-1:0] l2_mag;
	logic [NW-1:0] acc_mag;
	logic wb_sat;
	logic signed [VAL_W-1:0] wb_val;

	lpe_mac #(
		.FRAC_BITS(FRAC_BITS)
	) u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(mac_ctl),
		.s_mag(s_mag_q),
		.c2(c2_q),
		.l1_mag(l1_mag_q),
		.l2_mag(l2_mag_q),
		.neg1(neg1_q),
		.neg2(neg2_q),
		.acc(acc)
	);

	lpe_div #(
		.FRAC_BITS(FRAC_BITS),
		.MAX_DEGREE(MAX_DEGREE)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(d_q),
		.divisor(i_q),
		.sts(div_sts),
		.quotient(div_q)
	);

	// arithmetic feeding the step registers
	always_comb begin
		deg_ext = NCMP'(cfg_degree_q);
		n_in = (deg_ext > NCMP'(MAX_DEGREE)) ? IW'(MAX_DEGREE) : IW'(deg_ext);
		l1_init = signed'((VAL_W'(cfg_alpha_q) + VAL_W'(1)) << FRAC_BITS)
			- VAL_W'(sample.x_value);
		coef = (SW'(i_q) << 1) - SW'(1) + SW'(a_q);
		s_val = signed'(coef << FRAC_BITS) - SW'(x_q);
		s_mag = s_val[SW-1] ? AW'(-s_val) : AW'(s_val);
		c2 = AW'(i_q) - AW'(1) + AW'(a_q);
		l1_mag = l1_q[VAL_W-1] ? VAL_W'(-l1_q) : VAL_W'(l1_q);
		l2_mag = l2_q[VAL_W-1] ? VAL_W'(-l2_q) : VAL_W'(l2_q);
		acc_mag = acc[NW-1] ? NW'(-acc) : NW'(acc);
	end

	// clamp the divided step value to the 48-bit range
	always_comb begin
		if (dneg_q) begin
			wb_sat = div_sts.ovf || (div_q[VAL_W-1] && (|div_q[VAL_W-2:0]));
			wb_val = wb_sat ? VAL_MIN : VAL_W'(-div_q);
		end else begin
			wb_sat = div_sts.ovf || div_q[VAL_W-1];
			wb_val = wb_sat ? VAL_MAX : div_q;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sample.valid) begin
					state_d = (n_in < IW'(2)) ? ST_DONE : ST_PREP;
				end
			end
			ST_PREP: state_d = ST_MUL;
			ST_MUL: begin
				if (pass_q == PASS_W'(MUL_PASSES)) begin
					state_d = ST_ABS;
				end
			end
			ST_ABS: state_d = ST_DLD;
			ST_DLD: state_d = ST_DIV;
			ST_DIV: begin
				if (div_sts.done) begin
					state_d = ST_WB;
				end
			end
			ST_WB: state_d = (i_q == n_q) ? ST_DONE : ST_PREP;
			ST_DONE: begin
				if (!res_valid_q || result.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sample.ready = 1'b0;
		mac_ctl = '0;
		mac_ctl.pass = pass_q;
		div_start = 1'b0;
		res_load = 1'b0;
		case (state_q)
			ST_IDLE: sample.ready = 1'b1;
			ST_PREP: mac_ctl.clear = 1'b1;
			ST_MUL: mac_ctl.mul_en = (pass_q < PASS_W'(MUL_PASSES));
			ST_DLD: div_start = 1'b1;
			ST_DONE: res_load = !res_valid_q || result.ready;
			default: sample.ready = 1'b0;
		endcase
	end

	assign accept = sample.valid && sample.ready;
	assign cfg.ready = 1'b1;
	assign result.valid = res_valid_q;
	assign result.poly_value = poly_q;
	assign result.saturated = sat_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q <= '0;
			res_valid_q <= 1'b0;
			cfg_degree_q <= '0;
			cfg_alpha_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PREP) begin
				pass_q <= '0;
			end else if (state_q == ST_MUL) begin
				pass_q <= pass_q + PASS_W'(1);
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_IDX_DEGREE) begin
					cfg_degree_q <= cfg.data[DEG_W-1:0];
				end else if (cfg.index == CFG_IDX_ALPHA) begin
					cfg_alpha_q <= cfg.data[ALPHA_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= sample.x_value;
			n_q <= n_in;
			a_q <= cfg_alpha_q;
			i_q <= IW'(2);
			l2_q <= ONE_VAL;
			l1_q <= l1_init;
			sat_q <= 1'b0;
		end
		if (state_q == ST_PREP) begin
			s_mag_q <= s_mag;
			c2_q <= c2;
			l1_mag_q <= l1_mag;
			l2_mag_q <= l2_mag;
			neg1_q <= s_val[SW-1] ^ l1_q[VAL_W-1];
			neg2_q <= !l2_q[VAL_W-1];
		end
		if (state_q == ST_ABS) begin
			d_q <= acc_mag[NW-1:FRAC_BITS];
			dneg_q <= acc[NW-1];
		end
		if (state_q == ST_WB) begin
			l2_q <= l1_q;
			l1_q <= wb_val;
			sat_q <= sat_q | wb_sat;
			i_q <= i_q + IW'(1);
		end
		if (res_load) begin
			poly_q <= (n_q == '0) ? ONE_VAL : l1_q;
			sat_out_q <= sat_q;
		end
	end

	`LPE_ASSERT_IMP(a_div_done_in_div, clk, arst_n, div_sts.done, state_q == ST_DIV, "divider finished outside its wait state")
	`LPE_ASSERT_IMP(a_step_in_range, clk, arst_n, state_q == ST_WB, (i_q <= n_q) && (i_q > IW'(1)), "step index outside 2..degree")
	`LPE_ASSERT_IMP(a_low_degree_exact, clk, arst_n, state_q == ST_DONE, (n_q > IW'(1)) || !sat_q, "saturation flagged for degree below two")
	`LPE_ASSERT_NXT(a_accept_starts, clk, arst_n, accept, (state_q == ST_PREP) || (state_q == ST_DONE), "accepted sample did not start a computation")

endmodule

FILE: rtl/lpe_mac.sv
module lpe_mac import lpe_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input lpe_mac_ctl_t ctl,
	input logic [s_width(FRAC_BITS)-2:0] s_mag,
	input logic [s_width(FRAC_BITS)-2:0] c2,
	input logic [VAL_W-1:0] l1_mag,
	input logic [VAL_W-1:0] l2_mag,
	input logic neg1,
	input logic neg2,
	output logic signed [s_width(FRAC_BITS)+VAL_W-1:0] acc
);

	localparam int AW = s_width(FRAC_BITS) - 1;
	localparam int NW = AW + 1 + VAL_W;
	localparam int PW = AW + CH_W;
	localparam int CI_W = $clog2(NUM_CH);
	localparam int SH_W = $clog2((NUM_CH - 1) * CH_W + FRAC_BITS + 1);

	logic sel_l2;
	logic [PASS_W-1:0] chunk;
	logic [CI_W-1:0] ci;
	logic [AW-1:0] op_a;
	logic [CH_W-1:0] op_b;
	logic [SH_W-1:0] sh;
	logic [NW-1:0] term;

	logic [PW-1:0] prod_s1;
	logic [SH_W-1:0] sh_s1;
	logic neg_s1;
	logic vld_s1;

	// passes 0..2 take s * l1 chunks, passes 3..5 take c2 * l2 chunks
	always_comb begin
		sel_l2 = (ctl.pass >= PASS_W'(NUM_CH));
		chunk = sel_l2 ? (ctl.pass - PASS_W'(NUM_CH)) : ctl.pass;
		ci = chunk[CI_W-1:0];
		op_a = sel_l2 ? c2 : s_mag;
		op_b = sel_l2 ? l2_mag[ci*CH_W +: CH_W] : l1_mag[ci*CH_W +: CH_W];
		sh = SH_W'(int'(ci) * CH_W + (sel_l2 ? FRAC_BITS : 0));
	end

	assign term = NW'(prod_s1) << sh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= PW'(op_a) * PW'(op_b);
			sh_s1 <= sh;
			neg_s1 <= sel_l2 ? neg2 : neg1;
		end
		if (ctl.clear) begin
			acc <= '0;
		end else if (vld_s1) begin
			acc <= neg_s1 ? (acc - signed'(term)) : (acc + signed'(term));
		end
	end

endmodule

FILE: rtl/lpe_div.sv
module lpe_div import lpe_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int MAX_DEGREE = 31
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [s_width(FRAC_BITS)+VAL_W-FRAC_BITS-1:0] dividend,
	input logic [idx_width(MAX_DEGREE)-1:0] divisor,
	output lpe_div_sts_t sts,
	output logic [VAL_W-1:0] quotient
);

	localparam int DW = s_width(FRAC_BITS) + VAL_W - FRAC_BITS;
	localparam int TW = DW - VAL_W;
	localparam int IW = idx_width(MAX_DEGREE);
	localparam int RW = IW + 1;
	localparam int CNT_W = $clog2(DIV_CYCLES);

	logic busy_q;
	logic done_q;
	logic ovf_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IW-1:0] rem_q;
	logic [VAL_W-1:0] quo_q;

	logic [IW-1:0] rem_d;
	logic [VAL_W-1:0] quo_d;

	// dividend bits leave the top of quo_q while quotient bits enter at the bottom
	always_comb begin
		logic [RW-1:0] r_t;
		logic [IW-1:0] r_cur;
		logic [VAL_W-1:0] w;
		r_cur = rem_q;
		w = quo_q;
		for (int j = 0; j < DIV_BPC; j++) begin
			r_t = {r_cur, w[VAL_W-1]};
			w = {w[VAL_W-2:0], 1'b0};
			if (r_t >= {1'b0, divisor}) begin
				r_t = r_t - {1'b0, divisor};
				w[0] = 1'b1;
			end
			r_cur = r_t[IW-1:0];
		end
		rem_d = r_cur;
		quo_d = w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// upper part at or above the divisor means the quotient needs more than 48 bits
	always_ff @(posedge clk) begin
		if (start) begin
			ovf_q <= (dividend[DW-1:VAL_W] >= TW'(divisor));
			rem_q <= IW'(dividend[DW-1:VAL_W]);
			quo_q <= dividend[VAL_W-1:0];
		end else if (busy_q) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	assign sts.done = done_q;
	assign sts.ovf = ovf_q;
	assign quotient = quo_q;

endmodule
